### hw/rtl/assert_macros.svh
// Assertion helpers. Every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons holds in the same cycle as ante
`define PTBL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after ante
`define PTBL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ptbl_pkg.sv
package ptbl_pkg;

  localparam int DEF_USER_SLOTS = 256;
  localparam int DEF_TICK_WIDTH = 32;

  // field widths
  localparam int SLOT_IN_W  = 8;
  localparam int NOW_W      = 32;
  localparam int TICK_MAX_W = 48;
  localparam int MAXTOK_W   = 16;
  localparam int RATE_W     = 32;
  localparam int FRAC_W     = 32;
  localparam int LEVEL_W    = 48;
  localparam int COUNT_W    = 32;
  localparam int TICKS_W    = 48;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 152;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE = 1'd1;

  localparam logic [MAXTOK_W-1:0] MAX_TOKENS_RST  = 16'd10;
  localparam logic [RATE_W-1:0]   REFILL_RATE_RST = 32'd4295;

  // Q16.32 constants
  localparam logic [LEVEL_W-1:0] ONE_TOKEN = 48'h0001_0000_0000;
  localparam logic [TICKS_W-1:0] TICKS_SAT = 48'hFFFF_FFFF_FFFF;

  // radix-2 divider: one quotient bit per step
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic elapse;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic refill;
    logic take;
    logic prep;
    logic div_step;
    logic out_load;
  } ptbl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
  } ptbl_sts_t;

endpackage

### hw/rtl/ptbl_ram.sv
module ptbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/ptbl_ctrl.sv
module ptbl_ctrl
  import ptbl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ptbl_sts_t sts,
  output ptbl_cmd_t cmd
);

`include "assert_macros.svh"

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ELAPSE = 4'd2;
  localparam logic [3:0] S_MUL_LO = 4'd3;
  localparam logic [3:0] S_MUL_HI = 4'd4;
  localparam logic [3:0] S_SUM    = 4'd5;
  localparam logic [3:0] S_REFILL = 4'd6;
  localparam logic [3:0] S_TAKE   = 4'd7;
  localparam logic [3:0] S_PREP   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ELAPSE;
        end
      end
      S_ELAPSE: begin
        cmd.elapse = 1'b1;
        state_nxt  = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_REFILL;
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        state_nxt  = S_TAKE;
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `PTBL_ASSERT_NEXT(a_one_request_in_flight, in_tvalid && in_tready, !in_tready,
                    "ctrl: second request taken while one is in flight")
  `PTBL_ASSERT_NEXT(a_load_shows_result, cmd.out_load, out_tvalid,
                    "ctrl: loaded result not presented")
  `PTBL_ASSERT_NOW(a_load_never_drops, cmd.out_load && out_valid_r, out_tready,
                   "ctrl: result overwritten before it was taken")

endmodule

### hw/rtl/ptbl_dpath.sv
module ptbl_dpath
  import ptbl_pkg::*;
#(
  parameter int USER_SLOTS = DEF_USER_SLOTS,
  parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptbl_cmd_t             cmd,
  output ptbl_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SLOT_IN_W-1:0]  in_user_slot,
  input  logic [NOW_W-1:0]      in_now_tick,
  output logic                  out_allowed,
  output logic [MAXTOK_W-1:0]   out_limit,
  output logic [MAXTOK_W-1:0]   out_remaining,
  output logic [TICKS_W-1:0]    out_reset_ticks,
  output logic [COUNT_W-1:0]    out_allowed_count,
  output logic [COUNT_W-1:0]    out_rejected_count
);

`include "assert_macros.svh"

  localparam int SLOT_W   = $clog2(USER_SLOTS);
  localparam int RAM_W    = 1 + LEVEL_W + TICK_WIDTH;
  localparam int PAD_W    = 2 * RATE_W - TICK_WIDTH;
  localparam int PROD_W   = 2 * RATE_W;
  localparam int SUM_W    = PROD_W + RATE_W;
  localparam int ADD_W    = LEVEL_W + 1;
  localparam int LUT_N    = 1 << SLOT_IN_W;

  // configuration and counters
  logic [MAXTOK_W-1:0] max_tokens_r;
  logic [RATE_W-1:0]   refill_rate_r;
  logic [COUNT_W-1:0]  admit_r, reject_r;
  logic [SLOT_W-1:0]   clr_addr_r;

  // per-request working registers
  logic [SLOT_W-1:0]     slot_r;
  logic [TICK_WIDTH-1:0] now_r;
  logic [TICK_WIDTH-1:0] elapsed_r;
  logic [LEVEL_W-1:0]    deficit_r;
  logic                  full_r;
  logic [PROD_W-1:0]     prod_r, plo_r;
  logic [ADD_W-1:0]      add_r;
  logic [LEVEL_W-1:0]    level_r, level_nxt;
  logic                  allowed_r;
  logic [LEVEL_W-1:0]    dq_r;
  logic [RATE_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;

  logic                  out_allowed_r;
  logic [MAXTOK_W-1:0]   out_limit_r, out_remaining_r;
  logic [TICKS_W-1:0]    out_ticks_r, ticks_nxt;
  logic [COUNT_W-1:0]    out_admit_r, out_reject_r;

  // slot folding table: user_slot mod USER_SLOTS
  logic [SLOT_W-1:0] slot_lut [LUT_N];
  for (genvar g = 0; g < LUT_N; g++) begin : g_lut
    assign slot_lut[g] = SLOT_W'(g % USER_SLOTS);
  end

  logic [TICK_MAX_W-1:0] now_ext;
  assign now_ext = {{(TICK_MAX_W-NOW_W){1'b0}}, in_now_tick};

  // bucket memory: {valid, level, last refill tick}
  logic [RAM_W-1:0]      rd_data, wr_data;
  logic [SLOT_W-1:0]     wr_addr;
  logic                  wr_en;
  logic                  rd_valid;
  logic [LEVEL_W-1:0]    rd_level;
  logic [TICK_WIDTH-1:0] rd_tick;

  assign rd_valid = rd_data[RAM_W-1];
  assign rd_level = rd_data[TICK_WIDTH +: LEVEL_W];
  assign rd_tick  = rd_data[TICK_WIDTH-1:0];

  logic [LEVEL_W-1:0] cap;
  assign cap = {max_tokens_r, {FRAC_W{1'b0}}};

  // take one token
  logic take_ge, allowed_w;
  assign take_ge   = level_r >= ONE_TOKEN;
  assign allowed_w = !rd_valid || take_ge;
  assign level_nxt = take_ge ? level_r - ONE_TOKEN : level_r;

  assign wr_en   = cmd.clr_wr || cmd.take;
  assign wr_addr = cmd.clr_wr ? clr_addr_r : slot_r;
  assign wr_data = cmd.clr_wr ? '0 : {1'b1, level_nxt, now_r};

  ptbl_ram #(
    .WIDTH(RAM_W),
    .DEPTH(USER_SLOTS)
  ) u_bucket_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.load),
    .rd_addr(slot_lut[in_user_slot]),
    .rd_data(rd_data)
  );

  // elapsed * rate as two 32x32 partial products on one multiplier
  logic [PROD_W-1:0] elapsed_ext;
  logic [RATE_W-1:0] mul_a;
  logic [PROD_W-1:0] prod_w;
  logic [SUM_W-1:0]  sum_w;

  assign elapsed_ext = {{PAD_W{1'b0}}, elapsed_r};
  assign mul_a  = cmd.mul_hi ? elapsed_ext[PROD_W-1:RATE_W] : elapsed_ext[RATE_W-1:0];
  assign prod_w = mul_a * refill_rate_r;
  assign sum_w  = {prod_r, {RATE_W{1'b0}}} + {{RATE_W{1'b0}}, plo_r};

  // numerator for the reset time
  logic [LEVEL_W-1:0] num_nxt;
  always_comb begin
    if (!rd_valid) begin
      num_nxt = ONE_TOKEN;
    end else if (allowed_r) begin
      num_nxt = cap - level_r;
    end else begin
      num_nxt = ONE_TOKEN - level_r;
    end
  end

  // restoring division step
  logic [RATE_W:0] trial, trial_diff;
  logic            trial_ge;
  assign trial      = {rem_r, dq_r[LEVEL_W-1]};
  assign trial_diff = trial - {1'b0, refill_rate_r};
  assign trial_ge   = trial >= {1'b0, refill_rate_r};

  always_comb begin
    if (refill_rate_r == '0) begin
      ticks_nxt = TICKS_SAT;
    end else if (allowed_r) begin
      ticks_nxt = dq_r;
    end else begin
      ticks_nxt = dq_r + TICKS_W'(1);
    end
  end

  assign sts.clr_last = clr_addr_r == SLOT_W'(USER_SLOTS - 1);
  assign sts.div_last = div_cnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r  <= MAX_TOKENS_RST;
      refill_rate_r <= REFILL_RATE_RST;
      admit_r       <= '0;
      reject_r      <= '0;
      clr_addr_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_TOKENS:  max_tokens_r  <= cfg_wdata[MAXTOK_W-1:0];
          REG_REFILL_RATE: refill_rate_r <= cfg_wdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + SLOT_W'(1);
      end
      if (cmd.take) begin
        if (allowed_w) begin
          admit_r <= admit_r + COUNT_W'(1);
        end else begin
          reject_r <= reject_r + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r <= slot_lut[in_user_slot];
      now_r  <= now_ext[TICK_WIDTH-1:0];
    end
    if (cmd.elapse) begin
      elapsed_r <= now_r - rd_tick;
      full_r    <= rd_level >= cap;
      deficit_r <= cap - rd_level;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod_r <= prod_w;
    end
    if (cmd.mul_hi) begin
      plo_r <= prod_r;
    end
    if (cmd.sum) begin
      // anything at or above 2^49 is clamped; it already fills the bucket
      add_r <= (|sum_w[SUM_W-1:ADD_W]) ? '1 : sum_w[ADD_W-1:0];
    end
    if (cmd.refill) begin
      if (!rd_valid || full_r || add_r >= {1'b0, deficit_r}) begin
        level_r <= cap;
      end else begin
        level_r <= rd_level + add_r[LEVEL_W-1:0];
      end
    end
    if (cmd.take) begin
      level_r   <= level_nxt;
      allowed_r <= allowed_w;
    end
    if (cmd.prep) begin
      dq_r      <= num_nxt;
      rem_r     <= '0;
      div_cnt_r <= DIV_CNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      rem_r     <= trial_ge ? trial_diff[RATE_W-1:0] : trial[RATE_W-1:0];
      dq_r      <= {dq_r[LEVEL_W-2:0], trial_ge};
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_allowed_r   <= allowed_r;
      out_limit_r     <= max_tokens_r;
      out_remaining_r <= allowed_r ? level_r[LEVEL_W-1:FRAC_W] : '0;
      out_ticks_r     <= ticks_nxt;
      out_admit_r     <= admit_r;
      out_reject_r    <= reject_r;
    end
  end

  assign out_allowed        = out_allowed_r;
  assign out_limit          = out_limit_r;
  assign out_remaining      = out_remaining_r;
  assign out_reset_ticks    = out_ticks_r;
  assign out_allowed_count  = out_admit_r;
  assign out_rejected_count = out_reject_r;

  `PTBL_ASSERT_NEXT(a_refill_capped, cmd.refill, level_r <= cap,
                    "dpath: refilled level above capacity")
  `PTBL_ASSERT_NOW(a_rem_below_rate, cmd.div_step && refill_rate_r != '0,
                   rem_r < refill_rate_r, "dpath: divider remainder out of range")
  `PTBL_ASSERT_NEXT(a_one_count_per_take, cmd.take,
                    admit_r + reject_r == $past(admit_r) + $past(reject_r) + COUNT_W'(1),
                    "dpath: counters did not advance by one")

endmodule

### hw/rtl/per_user_token_bucket_limiter.sv
// Per-user token bucket policer. Each request (user slot, tick stamp) refills
// that user's Q16.32 bucket by elapsed ticks times refill_rate, capped at
// max_tokens, and admits it if a whole token is left; the first request of a
// slot finds the bucket full and takes one token. After reset the block first
// clears the valid flag of every slot, one slot a cycle, so requests are taken
// only once every slot is cleared (configuration writes are taken at once).
// A request then occupies the block until its result is loaded, and no new
// request is taken before: memory read, two partial products on the shared
// 32x32 multiplier, refill and token steps, and the radix-2 divider that
// gives reset_ticks. A finished result sits in the output register, so the
// next request is taken while it waits.
module per_user_token_bucket_limiter
  import ptbl_pkg::*;
#(
  parameter int USER_SLOTS = DEF_USER_SLOTS,
  parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] user_slot, [39:8] now_tick
  input  logic [IN_DATA_W-1:0]  in_tdata,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] allowed, [16:1] limit, [32:17] remaining, [80:33] reset_ticks,
  // [112:81] allowed_count, [144:113] rejected_count, [151:145] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  ptbl_cmd_t cmd;
  ptbl_sts_t sts;

  logic                allowed;
  logic [MAXTOK_W-1:0] limit, remaining;
  logic [TICKS_W-1:0]  reset_ticks;
  logic [COUNT_W-1:0]  allowed_count, rejected_count;

  ptbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptbl_dpath #(
    .USER_SLOTS(USER_SLOTS),
    .TICK_WIDTH(TICK_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_user_slot      (in_tdata[SLOT_IN_W-1:0]),
    .in_now_tick       (in_tdata[SLOT_IN_W +: NOW_W]),
    .out_allowed       (allowed),
    .out_limit         (limit),
    .out_remaining     (remaining),
    .out_reset_ticks   (reset_ticks),
    .out_allowed_count (allowed_count),
    .out_rejected_count(rejected_count)
  );

  localparam int OUT_USED_W = 1 + 2 * MAXTOK_W + TICKS_W + 2 * COUNT_W;

  assign out_tdata = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, rejected_count, allowed_count,
                      reset_ticks, remaining, limit, allowed};

endmodule
